// ===== rtl/mrtu_chk_pkg.sv =====
// ----------------------------------------------------------------------------
// mrtu_chk_pkg
// Types, codes and the CRC-16 byte update shared by the response checker.
// ----------------------------------------------------------------------------
package mrtu_chk_pkg;

    localparam int CNT_W = 9;

    localparam logic [CNT_W-1:0] WRITE_ACK_BYTES = 9'd8;
    localparam logic [CNT_W-1:0] EXCEPTION_BYTES = 9'd5;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  EXC_FLAG = 8'h80;
    localparam logic [7:0]  FC_READ  = 8'h03;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXCEPTION = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_CRC       = 3'd3;
    localparam logic [2:0] ST_PROTOCOL  = 3'd4;

    localparam logic KIND_WORD   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] REG_UNIT_ADDRESS      = 2'd0;
    localparam logic [1:0] REG_FUNCTION_CODE     = 2'd1;
    localparam logic [1:0] REG_READ_QTY          = 2'd2;
    localparam logic [1:0] REG_EXPECTED_ADDRESS  = 2'd3;

    typedef struct packed {
        logic [7:0]  unit_address;
        logic [7:0]  function_code;
        logic [6:0]  read_qty;
        logic [15:0] expected_address;
    } cfg_t;

    typedef struct packed {
        logic             kind;
        logic [15:0]      word;
        logic [CNT_W-1:0] count;
        logic             crc_ok;
        logic [3:0][7:0]  hdr;
    } job_t;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/mrtu_chk_front.sv =====
// ----------------------------------------------------------------------------
// mrtu_chk_front
// Accepts frame bytes, runs the CRC, byte delay, header capture and byte
// count, and classifies each byte into a data word, a status job or nothing.
// ----------------------------------------------------------------------------
module mrtu_chk_front import mrtu_chk_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       s_end_of_frame,
    output logic       job_valid,
    input  logic       job_ready,
    output job_t       job
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME_BYTES);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [15:0]      delay_reg, delay_next;
    logic [3:0][7:0]  hdr_reg, hdr_next;
    logic [7:0]       pend_reg, pend_next;

    logic             accept;
    logic             is_read;
    logic             in_range;
    logic             emit_word;
    logic [CNT_W-1:0] last_idx;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    assign is_read = (cfg.function_code == FC_READ);

    always_comb begin
        crc_next   = (count_reg >= 9'd2) ? crc_feed(crc_reg, delay_reg[15:8]) : crc_reg;
        delay_next = {delay_reg[7:0], s_rx_byte};
        hdr_next   = hdr_reg;
        if (count_reg < 9'd4) begin
            hdr_next[count_reg[1:0]] = s_rx_byte;
        end
        last_idx  = {1'b0, cfg.read_qty, 1'b0} + 9'd2;
        in_range  = is_read && (count_reg < MAX_CNT) && (count_reg >= 9'd3) &&
                    (count_reg <= last_idx);
        emit_word = in_range && !count_reg[0];
        pend_next = (in_range && count_reg[0]) ? s_rx_byte : pend_reg;
        count_next = (count_reg < MAX_CNT) ? count_reg + 9'd1 : count_reg;

        job.kind   = s_end_of_frame ? KIND_STATUS : KIND_WORD;
        job.word   = {pend_reg, s_rx_byte};
        job.count  = count_next;
        job.crc_ok = (count_next >= 9'd3) && (delay_next[15:8] == crc_next[7:0]) &&
                     (delay_next[7:0] == crc_next[15:8]);
        job.hdr    = hdr_next;
        job_valid  = s_valid && (s_end_of_frame || emit_word);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            crc_reg   <= CRC_INIT;
            delay_reg <= '0;
            hdr_reg   <= '0;
            pend_reg  <= '0;
        end else if (accept) begin
            if (s_end_of_frame) begin
                count_reg <= '0;
                crc_reg   <= CRC_INIT;
                delay_reg <= '0;
                hdr_reg   <= '0;
                pend_reg  <= '0;
            end else begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                delay_reg <= delay_next;
                hdr_reg   <= hdr_next;
                pend_reg  <= pend_next;
            end
        end
    end

endmodule

// ===== rtl/mrtu_chk_queue.sv =====
// ----------------------------------------------------------------------------
// mrtu_chk_queue
// Two-entry job queue between the byte front end and the result stage.
// ----------------------------------------------------------------------------
module mrtu_chk_queue import mrtu_chk_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  job_t in_job,
    output logic out_valid,
    input  logic out_ready,
    output job_t out_job
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    logic       pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

endmodule

// ===== rtl/mrtu_chk_back.sv =====
// ----------------------------------------------------------------------------
// mrtu_chk_back
// Judges status jobs against the configuration, passes data word jobs through,
// and holds the result in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module mrtu_chk_back import mrtu_chk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [15:0] m_data_word,
    output logic [2:0]  m_status,
    output logic [7:0]  m_exception_code,
    output logic        m_last
);

    logic        valid_reg;
    logic        kind_reg, kind_next;
    logic [15:0] word_reg, word_next;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  code_reg, code_next;

    logic             is_read;
    logic [CNT_W-1:0] need_len;
    logic             exc_frame;

    assign job_ready = !valid_reg || m_ready;

    always_comb begin
        is_read      = (cfg.function_code == FC_READ);
        need_len     = is_read ? ({1'b0, cfg.read_qty, 1'b0} + 9'd5) : WRITE_ACK_BYTES;
        exc_frame    = (job.count == EXCEPTION_BYTES) &&
                       (job.hdr[1] == (cfg.function_code | EXC_FLAG));
        kind_next    = job.kind;
        word_next    = 16'h0000;
        status_next  = ST_OK;
        code_next    = 8'h00;
        if (job.kind == KIND_WORD) begin
            word_next = job.word;
        end else if (exc_frame) begin
            if (job.crc_ok) begin
                status_next = ST_EXCEPTION;
                code_next   = job.hdr[2];
            end else begin
                status_next = ST_CRC;
            end
        end else if (job.count < need_len) begin
            status_next = ST_SHORT;
        end else if (!job.crc_ok) begin
            status_next = ST_CRC;
        end else if (job.hdr[0] != cfg.unit_address || job.hdr[1] != cfg.function_code) begin
            status_next = ST_PROTOCOL;
        end else if (is_read) begin
            if (job.hdr[2] != {cfg.read_qty, 1'b0}) begin
                status_next = ST_PROTOCOL;
            end
        end else if ({job.hdr[2], job.hdr[3]} != cfg.expected_address) begin
            status_next = ST_PROTOCOL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (job_ready) begin
            valid_reg <= job_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_ready && job_valid) begin
            kind_reg   <= kind_next;
            word_reg   <= word_next;
            status_reg <= status_next;
            code_reg   <= code_next;
        end
    end

    assign m_valid          = valid_reg;
    assign m_result_kind    = kind_reg;
    assign m_data_word      = word_reg;
    assign m_status         = status_reg;
    assign m_exception_code = code_reg;
    assign m_last           = (kind_reg == KIND_STATUS);

endmodule

// ===== rtl/modbus_rtu_response_checker_unit.sv =====
// ----------------------------------------------------------------------------
// modbus_rtu_response_checker_unit
// Modbus RTU response frame checker with CRC-16 and function 3 word output.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one received byte per request, s_end_of_frame set
//   on the final byte of the frame. The m_ channel returns results: a
//   tentative register word (result kind 0) for each complete word of a
//   function 3 read, and one final status (kind 1, last set) per frame.
//   Bytes that complete nothing produce no result.
//   The cfg_ port writes the expected unit, function, quantity and echoed
//   address; write only between frames.
//   Throughput is one byte per cycle while s_ready is high; the front stage
//   updates the CRC a whole byte at a time. A result reaches m_ through the
//   queue entry, written at the edge that accepts its byte, and then the
//   output register, loaded from the queue when it has room.
//   When m_ready is low the output register holds its result, the two-entry
//   queue fills and s_ready drops once it is full; no result is lost.
//   Reset clears the frame state, empties the queue and output register,
//   and loads the configuration defaults 1, 3, 1 and 0.
// ----------------------------------------------------------------------------
module modbus_rtu_response_checker_unit import mrtu_chk_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_end_of_frame,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [15:0] m_data_word,
    output logic [2:0]  m_status,
    output logic [7:0]  m_exception_code,
    output logic        m_last,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic fq_valid, fq_ready;
    job_t fq_job;
    logic qb_valid, qb_ready;
    job_t qb_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.unit_address      <= 8'd1;
            cfg_reg.function_code     <= 8'd3;
            cfg_reg.read_qty          <= 7'd1;
            cfg_reg.expected_address  <= 16'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_UNIT_ADDRESS:      cfg_reg.unit_address      <= cfg_wdata[7:0];
                REG_FUNCTION_CODE:     cfg_reg.function_code     <= cfg_wdata[7:0];
                REG_READ_QTY:          cfg_reg.read_qty          <= cfg_wdata[6:0];
                REG_EXPECTED_ADDRESS:  cfg_reg.expected_address  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    mrtu_chk_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .s_end_of_frame (s_end_of_frame),
        .job_valid      (fq_valid),
        .job_ready      (fq_ready),
        .job            (fq_job)
    );

    mrtu_chk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    mrtu_chk_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg_reg),
        .job_valid        (qb_valid),
        .job_ready        (qb_ready),
        .job              (qb_job),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_result_kind    (m_result_kind),
        .m_data_word      (m_data_word),
        .m_status         (m_status),
        .m_exception_code (m_exception_code),
        .m_last           (m_last)
    );

    a_status_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_STATUS |-> m_last && m_data_word == 16'h0000)
        else $error("status result without last or with data");

    a_word_is_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_result_kind == KIND_WORD |->
            !m_last && m_status == ST_OK && m_exception_code == 8'h00)
        else $error("data word result carries status fields");

    a_code_only_on_exc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_EXCEPTION |-> m_exception_code == 8'h00)
        else $error("exception code outside an exception status");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && !s_ready |=> !s_ready || m_ready || !m_valid)
        else $error("input reopened while output stalled and queue full");

endmodule
